// ===== rtl/bhpq_pkg.sv =====
// Shared codes and types for the binary-heap priority queue.
package bhpq_pkg;

    // Command codes carried on the request channel.
    localparam logic CMD_INSERT  = 1'b0;
    localparam logic CMD_EXTRACT = 1'b1;

    // Status codes returned with every result.
    localparam logic [1:0] STS_OK    = 2'd0;
    localparam logic [1:0] STS_FULL  = 2'd1;
    localparam logic [1:0] STS_EMPTY = 2'd2;

    // Control half of the token that walks the chain of level cells.
    typedef struct packed {
        logic vld;   // a value is moving into the cell
        logic up;    // 1 while sifting toward the root, 0 while sifting down
    } t_tok_ctl;

endpackage

// ===== rtl/bhpq_ifs.sv =====
// Request and response channel interfaces of the binary-heap priority queue.
interface bhpq_in_if #(
    parameter int DATA_WIDTH = 32
);
    logic                         valid;
    logic                         ready;
    logic                         cmd;
    logic signed [DATA_WIDTH-1:0] value;

    modport source (output valid, output cmd, output value, input ready);
    modport sink   (input valid, input cmd, input value, output ready);
endinterface

interface bhpq_out_if #(
    parameter int DATA_WIDTH = 32,
    parameter int FILL_W     = 7
);
    logic                         valid;
    logic                         ready;
    logic signed [DATA_WIDTH-1:0] out_value;
    logic [1:0]                   status;
    logic [FILL_W-1:0]            fill;

    modport source (output valid, output out_value, output status, output fill, input ready);
    modport sink   (input valid, input out_value, input status, input fill, output ready);
endinterface

// ===== rtl/bhpq_cell.sv =====
// One level of the heap tree: level storage plus the step logic for a moving value.
module bhpq_cell #(
    parameter int LEVEL      = 0,
    parameter int DATA_WIDTH = 32,
    parameter int OFF_W      = 6,
    parameter int CNT_W      = 7
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_order,
    input  logic [CNT_W-1:0]          i_count,
    // Token arriving into this level.
    input  bhpq_pkg::t_tok_ctl        i_tok_ctl,
    input  logic [DATA_WIDTH-1:0]     i_tok_val,
    input  logic [OFF_W-1:0]          i_tok_off,
    // Token leaving this level toward a neighbor.
    output bhpq_pkg::t_tok_ctl        o_tok_ctl,
    output logic [DATA_WIDTH-1:0]     o_tok_val,
    output logic [OFF_W-1:0]          o_tok_off,
    // Read port of this level's storage, one row of two siblings per read.
    input  logic                      i_rd_en,
    input  logic [OFF_W-1:0]          i_rd_row,
    output logic [2*DATA_WIDTH-1:0]   o_rd_data,
    // Reads this level issues to its neighbors and the rows they return.
    output logic                      o_req_dn_en,
    output logic [OFF_W-1:0]          o_req_dn_row,
    output logic                      o_req_up_en,
    output logic [OFF_W-1:0]          o_req_up_row,
    input  logic [2*DATA_WIDTH-1:0]   i_dn_data,
    input  logic [2*DATA_WIDTH-1:0]   i_up_data,
    output logic                      o_done
);
    import bhpq_pkg::*;

    localparam int ROWS   = (LEVEL >= 2) ? 2 ** (LEVEL - 1) : 1;
    localparam int ROW_W  = (LEVEL >= 2) ? LEVEL - 1 : 1;
    localparam int IDX_W  = CNT_W + 1;
    localparam int BASE_L = 2 ** (LEVEL + 1) - 1;

    function automatic logic f_beats(input logic ord,
                                     input logic [DATA_WIDTH-1:0] a,
                                     input logic [DATA_WIDTH-1:0] b);
        f_beats = ord ? ($signed(a) > $signed(b)) : ($signed(a) < $signed(b));
    endfunction

    logic                  r_vld;
    logic                  r_ph;
    logic                  r_up;
    logic [DATA_WIDTH-1:0] r_val;
    logic [OFF_W-1:0]      r_off;
    logic [2*DATA_WIDTH-1:0] r_rd;

    logic [IDX_W-1:0]      w_idx_l;
    logic                  w_left;
    logic                  w_right;
    logic                  w_stop0;
    logic [DATA_WIDTH-1:0] w_lch;
    logic [DATA_WIDTH-1:0] w_rch;
    logic                  w_pick_r;
    logic [DATA_WIDTH-1:0] w_pick;
    logic [OFF_W-1:0]      w_pofs;
    logic [DATA_WIDTH-1:0] w_par;
    logic                  w_move;
    logic                  w_we;
    logic [DATA_WIDTH-1:0] w_wdata;
    logic [OFF_W-1:0]      w_row_full;

    // Child positions in heap order decide whether this node has children.
    assign w_idx_l = IDX_W'(BASE_L) + IDX_W'({r_off, 1'b0});
    assign w_left  = w_idx_l < {1'b0, i_count};
    assign w_right = (w_idx_l + IDX_W'(1)) < {1'b0, i_count};

    // In the first phase a value stops at once at the root or above no child.
    assign w_stop0 = r_up ? (LEVEL == 0) : !w_left;

    assign w_lch    = i_dn_data[DATA_WIDTH-1:0];
    assign w_rch    = i_dn_data[2*DATA_WIDTH-1:DATA_WIDTH];
    assign w_pick_r = w_right && f_beats(i_order, w_rch, w_lch);
    assign w_pick   = w_pick_r ? w_rch : w_lch;

    assign w_pofs = r_off >> 1;
    assign w_par  = w_pofs[0] ? i_up_data[2*DATA_WIDTH-1:DATA_WIDTH]
                              : i_up_data[DATA_WIDTH-1:0];

    assign w_move  = r_vld && r_ph &&
                     (r_up ? f_beats(i_order, r_val, w_par) : f_beats(i_order, w_pick, r_val));
    assign w_we    = r_vld && (r_ph || w_stop0);
    assign w_wdata = w_move ? (r_up ? w_par : w_pick) : r_val;

    assign o_tok_ctl.vld = w_move;
    assign o_tok_ctl.up  = r_up;
    assign o_tok_val     = r_val;
    assign o_tok_off     = r_up ? w_pofs : OFF_W'({r_off, w_pick_r});
    assign o_done        = w_we && !w_move;

    assign o_req_dn_en  = r_vld && !r_ph && !r_up && w_left;
    assign o_req_dn_row = r_off;
    assign o_req_up_en  = r_vld && !r_ph && r_up && (LEVEL != 0);
    assign o_req_up_row = r_off >> 2;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
            r_ph  <= 1'b0;
        end else if (i_tok_ctl.vld) begin
            r_vld <= 1'b1;
            r_ph  <= 1'b0;
        end else if (r_vld) begin
            if (!r_ph && !w_stop0) begin
                r_ph <= 1'b1;
            end else begin
                r_vld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_tok_ctl.vld) begin
            r_up  <= i_tok_ctl.up;
            r_val <= i_tok_val;
            r_off <= i_tok_off;
        end
    end

    assign w_row_full = r_off >> 1;
    assign o_rd_data  = r_rd;

    generate
        if (ROWS == 1) begin : g_regs
            logic [DATA_WIDTH-1:0] r_lo;
            logic [DATA_WIDTH-1:0] r_hi;

            always_ff @(posedge i_clk) begin
                if (w_we && !r_off[0]) begin
                    r_lo <= w_wdata;
                end
                if (w_we && r_off[0]) begin
                    r_hi <= w_wdata;
                end
                if (i_rd_en) begin
                    r_rd <= {r_hi, r_lo};
                end
            end
        end else begin : g_mem
            logic [DATA_WIDTH-1:0] mem_lo [ROWS];
            logic [DATA_WIDTH-1:0] mem_hi [ROWS];
            logic [ROW_W-1:0]      w_wrow;
            logic [ROW_W-1:0]      w_rrow;

            assign w_wrow = w_row_full[ROW_W-1:0];
            assign w_rrow = i_rd_row[ROW_W-1:0];

            always_ff @(posedge i_clk) begin
                if (w_we && !r_off[0]) begin
                    mem_lo[w_wrow] <= w_wdata;
                end
                if (w_we && r_off[0]) begin
                    mem_hi[w_wrow] <= w_wdata;
                end
                if (i_rd_en) begin
                    r_rd <= {mem_hi[w_rrow], mem_lo[w_rrow]};
                end
            end
        end
    endgenerate

endmodule

// ===== rtl/binary_heap_priority_queue.sv =====
// Top level of the binary-heap priority queue: command sequencer and chain of level cells.
//
//  Channel   Dir  Handshake          Payload
//  i_req     in   valid / ready      cmd, value
//  o_rsp     out  valid / ready      out_value, status, fill
//  i_cfg_*   in   write enable only  order (1 bit)
//
// An insert starts its climb at the transfer; an extract first reads the last entry and the
// root, then descends from the root. Each level climbed or descended is one registered
// neighbor read plus one compare and write-back. The next request is taken as soon as
// the result shows. Reset clears the count, the order and control state, not the entries;
// a stalled result blocks the next command's end.
module binary_heap_priority_queue #(
    parameter int CAPACITY   = 64,
    parameter int DATA_WIDTH = 32
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_cfg_we,
    input  logic          i_cfg_wdata,
    bhpq_in_if.sink       i_req,
    bhpq_out_if.source    o_rsp
);
    import bhpq_pkg::*;

    // The tree has one level for each bit of the entry count.
    localparam int LVLS  = $clog2(CAPACITY + 1);
    localparam int CNT_W = LVLS;
    localparam int OFF_W = LVLS - 1;
    localparam int LVL_W = $clog2(LVLS);

    // Sequencer states.
    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_LAST = 3'd1;   // read the last entry
    localparam logic [2:0] S_ROOT = 3'd2;   // capture last entry, read the root
    localparam logic [2:0] S_INJ  = 3'd3;   // capture root, start the sift-down
    localparam logic [2:0] S_RUN  = 3'd4;   // a value walks the chain
    localparam logic [2:0] S_DONE = 3'd5;   // hand the result to the output register

    logic [2:0]            r_state;
    logic [CNT_W-1:0]      r_count;
    logic                  r_order;
    logic [LVL_W-1:0]      r_lvl;
    logic [OFF_W-1:0]      r_off;
    logic [DATA_WIDTH-1:0] r_val;
    logic [DATA_WIDTH-1:0] r_res;
    logic [1:0]            r_sts;
    logic                  r_out_vld;
    logic [DATA_WIDTH-1:0] r_out_val;
    logic [1:0]            r_out_sts;
    logic [CNT_W-1:0]      r_out_fill;

    logic                  w_acc;
    logic                  w_full;
    logic [CNT_W-1:0]      w_pos1;
    logic [CNT_W-1:0]      w_tmp;
    logic [LVL_W-1:0]      w_lvl;
    logic [OFF_W-1:0]      w_off;

    logic                  w_inj_vld;
    logic                  w_inj_up;
    logic [LVL_W-1:0]      w_inj_lvl;
    logic [DATA_WIDTH-1:0] w_inj_val;
    logic [OFF_W-1:0]      w_inj_off;

    logic                  w_bus_up;
    logic [DATA_WIDTH-1:0] w_bus_val;
    logic [OFF_W-1:0]      w_bus_off;

    logic                  w_ctl_en;
    logic [LVL_W-1:0]      w_ctl_lvl;
    logic [OFF_W-1:0]      w_ctl_row;
    logic [OFF_W-1:0]      w_rq_row;

    t_tok_ctl              w_tout_ctl [LVLS];
    logic [DATA_WIDTH-1:0] w_tout_val [LVLS];
    logic [OFF_W-1:0]      w_tout_off [LVLS];
    logic [LVLS-1:0]       w_tdn;
    logic [LVLS-1:0]       w_tup;
    logic [LVLS-1:0]       w_tin_vld;
    logic [LVLS-1:0]       w_qdn;
    logic [LVLS-1:0]       w_qup;
    logic [OFF_W-1:0]      w_qdn_row [LVLS];
    logic [OFF_W-1:0]      w_qup_row [LVLS];
    logic [LVLS-1:0]       w_rd_en;
    logic [2*DATA_WIDTH-1:0] w_rd_data [LVLS];
    logic [2*DATA_WIDTH-1:0] w_up_in [LVLS];
    logic [2*DATA_WIDTH-1:0] w_dn_in [LVLS];
    logic [LVLS-1:0]       w_done;

    assign i_req.ready = (r_state == S_IDLE);
    assign w_acc       = i_req.valid && i_req.ready;
    assign w_full      = (r_count == CNT_W'(CAPACITY));

    // Position of the slot that an insert fills or an extract empties, in
    // one-based heap order: its top set bit is the level, the rest the offset.
    assign w_pos1 = (i_req.cmd == CMD_EXTRACT) ? r_count : r_count + CNT_W'(1);

    always_comb begin
        w_lvl = '0;
        for (int i = 0; i < CNT_W; i++) begin
            if (w_pos1[i]) begin
                w_lvl = LVL_W'(i);
            end
        end
        w_tmp        = w_pos1;
        w_tmp[w_lvl] = 1'b0;
        w_off        = w_tmp[OFF_W-1:0];
    end

    // An insert starts its climb in the leaf level at the transfer itself; an
    // extract starts its descent at the root once the last entry has been read.
    always_comb begin
        w_inj_vld = (r_state == S_INJ);
        w_inj_up  = 1'b0;
        w_inj_lvl = '0;
        w_inj_val = r_val;
        w_inj_off = '0;
        if (w_acc && (i_req.cmd == CMD_INSERT) && !w_full) begin
            w_inj_vld = 1'b1;
            w_inj_up  = 1'b1;
            w_inj_lvl = w_lvl;
            w_inj_val = i_req.value;
            w_inj_off = w_off;
        end
    end

    // Only one value moves at a time, so its payload rides a shared bus while
    // the valid bit steps between neighboring cells.
    always_comb begin
        w_bus_up  = w_inj_up;
        w_bus_val = w_inj_val;
        w_bus_off = w_inj_off;
        for (int c = 0; c < LVLS; c++) begin
            w_tdn[c] = w_tout_ctl[c].vld && !w_tout_ctl[c].up;
            w_tup[c] = w_tout_ctl[c].vld && w_tout_ctl[c].up;
            if (!w_inj_vld && w_tout_ctl[c].vld) begin
                w_bus_up  = w_tout_ctl[c].up;
                w_bus_val = w_tout_val[c];
                w_bus_off = w_tout_off[c];
            end
        end
    end

    // The sequencer reads the last entry and then the root for an extract.
    assign w_ctl_en  = (r_state == S_LAST) || (r_state == S_ROOT);
    assign w_ctl_lvl = (r_state == S_LAST) ? r_lvl : '0;
    assign w_ctl_row = (r_state == S_LAST) ? (r_off >> 1) : '0;

    always_comb begin
        w_rq_row = w_ctl_row;
        for (int c = 0; c < LVLS; c++) begin
            if (w_qdn[c]) begin
                w_rq_row = w_qdn_row[c];
            end
            if (w_qup[c]) begin
                w_rq_row = w_qup_row[c];
            end
        end
    end

    genvar l;
    generate
        for (l = 0; l < LVLS; l++) begin : g_lvl
            t_tok_ctl w_tin_ctl;

            if (l == 0) begin : g_top_edge
                assign w_up_in[l] = '0;
                assign w_tin_vld[l] = (w_inj_vld && (w_inj_lvl == LVL_W'(l))) ||
                                      ((l + 1 < LVLS) ? w_tup[(l + 1) % LVLS] : 1'b0);
            end else if (l == LVLS - 1) begin : g_bot_edge
                assign w_up_in[l] = w_rd_data[l - 1];
                assign w_tin_vld[l] = (w_inj_vld && (w_inj_lvl == LVL_W'(l))) ||
                                      w_tdn[l - 1];
            end else begin : g_mid
                assign w_up_in[l] = w_rd_data[l - 1];
                assign w_tin_vld[l] = (w_inj_vld && (w_inj_lvl == LVL_W'(l))) ||
                                      w_tdn[l - 1] || w_tup[l + 1];
            end

            if (l == LVLS - 1) begin : g_no_child
                assign w_dn_in[l] = '0;
                assign w_rd_en[l] = w_qdn[l - 1] ||
                                    (w_ctl_en && (w_ctl_lvl == LVL_W'(l)));
            end else if (l == 0) begin : g_root_rd
                assign w_dn_in[l] = w_rd_data[l + 1];
                assign w_rd_en[l] = w_qup[l + 1] ||
                                    (w_ctl_en && (w_ctl_lvl == LVL_W'(l)));
            end else begin : g_mid_rd
                assign w_dn_in[l] = w_rd_data[l + 1];
                assign w_rd_en[l] = w_qdn[l - 1] || w_qup[l + 1] ||
                                    (w_ctl_en && (w_ctl_lvl == LVL_W'(l)));
            end

            assign w_tin_ctl.vld = w_tin_vld[l];
            assign w_tin_ctl.up  = w_bus_up;

            bhpq_cell #(
                .LEVEL      (l),
                .DATA_WIDTH (DATA_WIDTH),
                .OFF_W      (OFF_W),
                .CNT_W      (CNT_W)
            ) u_cell (
                .i_clk        (i_clk),
                .i_rst_n      (i_rst_n),
                .i_order      (r_order),
                .i_count      (r_count),
                .i_tok_ctl    (w_tin_ctl),
                .i_tok_val    (w_bus_val),
                .i_tok_off    (w_bus_off),
                .o_tok_ctl    (w_tout_ctl[l]),
                .o_tok_val    (w_tout_val[l]),
                .o_tok_off    (w_tout_off[l]),
                .i_rd_en      (w_rd_en[l]),
                .i_rd_row     (w_rq_row),
                .o_rd_data    (w_rd_data[l]),
                .o_req_dn_en  (w_qdn[l]),
                .o_req_dn_row (w_qdn_row[l]),
                .o_req_up_en  (w_qup[l]),
                .o_req_up_row (w_qup_row[l]),
                .i_dn_data    (w_dn_in[l]),
                .i_up_data    (w_up_in[l]),
                .o_done       (w_done[l])
            );
        end
    endgenerate

    // Command sequencer, order register and the output register. The entry
    // count moves at the transfer, so the cells see the new count during the
    // walk and the result reports it as the fill.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_count   <= '0;
            r_order   <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_order <= i_cfg_wdata;
            end
            // In the done state the output register is reloaded instead.
            if (r_out_vld && o_rsp.ready && (r_state != S_DONE)) begin
                r_out_vld <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (w_acc) begin
                        r_res <= '0;
                        if (i_req.cmd == CMD_INSERT) begin
                            if (w_full) begin
                                r_sts   <= STS_FULL;
                                r_state <= S_DONE;
                            end else begin
                                r_count <= r_count + CNT_W'(1);
                                r_sts   <= STS_OK;
                                r_state <= S_RUN;
                            end
                        end else begin
                            if (r_count == '0) begin
                                r_sts   <= STS_EMPTY;
                                r_state <= S_DONE;
                            end else begin
                                r_count <= r_count - CNT_W'(1);
                                r_lvl   <= w_lvl;
                                r_off   <= w_off;
                                r_sts   <= STS_OK;
                                r_state <= S_LAST;
                            end
                        end
                    end
                end
                S_LAST: begin
                    r_state <= S_ROOT;
                end
                S_ROOT: begin
                    r_val   <= r_off[0] ? w_rd_data[r_lvl][2*DATA_WIDTH-1:DATA_WIDTH]
                                        : w_rd_data[r_lvl][DATA_WIDTH-1:0];
                    r_state <= S_INJ;
                end
                S_INJ: begin
                    r_res   <= w_rd_data[0][DATA_WIDTH-1:0];
                    r_state <= S_RUN;
                end
                S_RUN: begin
                    if (|w_done) begin
                        r_state <= S_DONE;
                    end
                end
                S_DONE: begin
                    if (!r_out_vld || o_rsp.ready) begin
                        r_out_vld  <= 1'b1;
                        r_out_val  <= r_res;
                        r_out_sts  <= r_sts;
                        r_out_fill <= r_count;
                        r_state    <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_rsp.valid     = r_out_vld;
    assign o_rsp.out_value = r_out_val;
    assign o_rsp.status    = r_out_sts;
    assign o_rsp.fill      = r_out_fill;

    // The entry count never passes the capacity.
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(CAPACITY))
        else $error("entry count beyond capacity");

    // At most one level cell takes in a moving value in any cycle.
    a_one_token: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0(w_tin_vld))
        else $error("more than one value moving in the chain");

    // A walk can only finish while the sequencer waits for it.
    a_done_in_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (|w_done) |-> (r_state == S_RUN))
        else $error("walk finished outside the run state");

    // Once the output register is free, a finished result shows in the next cycle.
    a_result_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == S_DONE) && (!r_out_vld || o_rsp.ready)) |=> (r_out_vld && (r_state == S_IDLE)))
        else $error("finished result not presented");

endmodule

// ===== verif/tb_binary_heap_priority_queue.sv =====
// Self-checking testbench for the binary-heap priority queue: directed table, then random traffic.
`timescale 1ns / 100ps

module tb_binary_heap_priority_queue;

    import bhpq_pkg::*;

    localparam int CAPACITY   = 64;
    localparam int DATA_WIDTH = 32;
    localparam int FILL_W     = 7;

    // Idle cycles left before a register write and at the end of the run.
    localparam int SETTLE_CYCLES = 24;
    localparam int RANDOM_ITEMS  = 1460;
    localparam int DRAIN_LIMIT   = 20000;

    // One result as it leaves the response channel.
    typedef struct packed {
        logic signed [DATA_WIDTH-1:0] out_value;
        logic [1:0]                   status;
        logic [FILL_W-1:0]            fill;
    } t_result;

    // Kinds of rows in the directed table.
    typedef enum logic [1:0] {
        ROW_ITEM,   // one command transfer
        ROW_ORDER,  // write the order register with value[0]
        ROW_FILL    // insert random values until the heap is full
    } t_row_kind;

    typedef struct packed {
        t_row_kind              kind;
        logic                   cmd;
        logic [DATA_WIDTH-1:0]  value;
        logic                   typed;  // the expected result is written in the row
        t_result                want;
    } t_row;

    logic i_clk;
    logic i_rst_n;
    logic i_cfg_we;
    logic i_cfg_wdata;

    bhpq_in_if  #(.DATA_WIDTH(DATA_WIDTH))                  req_if ();
    bhpq_out_if #(.DATA_WIDTH(DATA_WIDTH), .FILL_W(FILL_W)) rsp_if ();

    binary_heap_priority_queue #(
        .CAPACITY   (CAPACITY),
        .DATA_WIDTH (DATA_WIDTH)
    ) dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_req       (req_if),
        .o_rsp       (rsp_if)
    );

    // Shadow copy of the heap, kept in step with every accepted transfer.
    logic signed [DATA_WIDTH-1:0] heap_model [CAPACITY];
    int                           heap_fill;
    logic                         heap_order;

    // Results predicted at request transfer, oldest first.
    t_result pending_results [$];
    int      mismatch_count;

    // While set, neither side of the channels idles.
    logic quiet;

    t_row directed_rows [$];

    // 10 ns clock.
    initial i_clk = 1'b0;
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Guard against a hung block.
    initial begin
        #5_000_000;
        $display("Mismatches found");
        $finish;
    end

    // True when a must sit above b in the heap. Ties never move a value.
    function automatic logic outranks(input logic signed [DATA_WIDTH-1:0] a,
                                      input logic signed [DATA_WIDTH-1:0] b);
        return heap_order ? (a > b) : (a < b);
    endfunction

    // Applies one command to the shadow heap and returns the result it gives.
    task automatic heap_apply(input logic cmd_i, input logic signed [DATA_WIDTH-1:0] val_i,
                              output t_result res);
        int                           pos;
        int                           parent;
        int                           left;
        int                           pick;
        logic signed [DATA_WIDTH-1:0] tmp;
        res.out_value = '0;
        res.status    = STS_OK;
        if (cmd_i == CMD_INSERT) begin
            if (heap_fill >= CAPACITY) begin
                res.status = STS_FULL;
            end else begin
                heap_model[heap_fill] = val_i;
                heap_fill++;
                pos = heap_fill - 1;
                // Climb while the new value strictly beats its parent.
                while (pos > 0) begin
                    parent = (pos - 1) / 2;
                    if (!outranks(heap_model[pos], heap_model[parent])) break;
                    tmp                = heap_model[pos];
                    heap_model[pos]    = heap_model[parent];
                    heap_model[parent] = tmp;
                    pos                = parent;
                end
            end
        end else begin
            if (heap_fill == 0) begin
                res.status = STS_EMPTY;
            end else begin
                res.out_value = heap_model[0];
                heap_fill--;
                heap_model[0] = heap_model[heap_fill];
                pos = 0;
                // Descend toward the preferred child; the left one wins a tie.
                forever begin
                    left = 2 * pos + 1;
                    if (left >= heap_fill) break;
                    pick = left;
                    if (left + 1 < heap_fill && outranks(heap_model[left + 1], heap_model[left]))
                        pick = left + 1;
                    if (!outranks(heap_model[pick], heap_model[pos])) break;
                    tmp              = heap_model[pos];
                    heap_model[pos]  = heap_model[pick];
                    heap_model[pick] = tmp;
                    pos              = pick;
                end
            end
        end
        res.fill = heap_fill[FILL_W-1:0];
    endtask

    function automatic t_row make_row(input t_row_kind kind, input logic cmd_i,
                                      input logic [DATA_WIDTH-1:0] val_i, input logic typed,
                                      input logic [DATA_WIDTH-1:0] want_value,
                                      input logic [1:0] want_status,
                                      input logic [FILL_W-1:0] want_fill);
        t_row r;
        r.kind           = kind;
        r.cmd            = cmd_i;
        r.value          = val_i;
        r.typed          = typed;
        r.want.out_value = want_value;
        r.want.status    = want_status;
        r.want.fill      = want_fill;
        return r;
    endfunction

    // Values lean on the extremes and on a narrow band, so that ties are common.
    function automatic logic [DATA_WIDTH-1:0] random_value();
        case ($urandom_range(9))
            0:       return 32'h8000_0000;
            1:       return 32'h7FFF_FFFF;
            2, 3:    return $urandom_range(6) - 3;
            default: return $urandom;
        endcase
    endfunction

    task automatic log_mismatch(input string field, input logic [DATA_WIDTH-1:0] want,
                                input logic [DATA_WIDTH-1:0] got);
        mismatch_count++;
        if (mismatch_count <= 10)
            $display("mismatch in %s at %0t ns: expected %h, got %h", field, $time, want, got);
    endtask

    // Offers one command, possibly after a few idle cycles, and records the
    // expected result once the transfer has taken place. Every path through
    // this task leaves the process at a rising edge with the channel driven.
    task automatic send_item(input logic cmd_i, input logic [DATA_WIDTH-1:0] val_i,
                             input logic typed, input t_result typed_want);
        t_result predicted;
        while (!quiet && $urandom_range(99) < 16) begin
            req_if.valid <= 1'b0;
            @(posedge i_clk);
        end
        req_if.valid <= 1'b1;
        req_if.cmd   <= cmd_i;
        req_if.value <= val_i;
        do @(posedge i_clk); while (!req_if.ready);
        heap_apply(cmd_i, val_i, predicted);
        pending_results.push_back(typed ? typed_want : predicted);
    endtask

    // The order register is written only with the block idle: the sender stops,
    // every expected result has to come back, and a few idle cycles follow.
    task automatic write_order(input logic order_i);
        req_if.valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= order_i;
        @(posedge i_clk);
        heap_order = order_i;
        i_cfg_we   <= 1'b0;
    endtask

    // Response side: random back-pressure and the field-by-field check. Values
    // are sampled at the rising edge, before any register in the block moves.
    always @(posedge i_clk) begin : rsp_check
        t_result want;
        rsp_if.ready <= quiet || ($urandom_range(99) >= 16);
        if (i_rst_n && rsp_if.valid && rsp_if.ready) begin
            if (pending_results.size() == 0) begin
                log_mismatch("unexpected result", '0, rsp_if.out_value);
            end else begin
                want = pending_results.pop_front();
                if (rsp_if.out_value !== want.out_value)
                    log_mismatch("out_value", want.out_value, rsp_if.out_value);
                if (rsp_if.status !== want.status)
                    log_mismatch("status", want.status, rsp_if.status);
                if (rsp_if.fill !== want.fill)
                    log_mismatch("fill", want.fill, rsp_if.fill);
            end
        end
    end

    initial begin : stimulus
        int      sent;
        int      run_len;
        int      insert_pct;
        int      drain;
        logic    cmd_pick;
        t_result no_want;

        no_want        = '0;
        heap_fill      = 0;
        heap_order     = 1'b0;
        mismatch_count = 0;
        quiet          <= 1'b0;
        i_rst_n        <= 1'b0;
        i_cfg_we       <= 1'b0;
        i_cfg_wdata    <= 1'b0;
        req_if.valid   <= 1'b0;
        req_if.cmd     <= CMD_INSERT;
        req_if.value   <= '0;

        // Smallest first: extremes, a tie of equal values, extracts down to empty.
        // The last extract from an empty heap carries a value with every bit set,
        // which the block has to ignore.
        directed_rows.push_back(make_row(ROW_ITEM, CMD_EXTRACT, 32'h0000_0000, 1, 0, STS_EMPTY, 0));
        directed_rows.push_back(make_row(ROW_ITEM, CMD_INSERT, 32'h7FFF_FFFF, 1, 0, STS_OK, 1));
        directed_rows.push_back(make_row(ROW_ITEM, CMD_INSERT, 32'h8000_0000, 1, 0, STS_OK, 2));
        directed_rows.push_back(make_row(ROW_ITEM, CMD_INSERT, 32'h0000_0000, 1, 0, STS_OK, 3));
        directed_rows.push_back(make_row(ROW_ITEM, CMD_INSERT, 32'hFFFF_FFFF, 1, 0, STS_OK, 4));
        directed_rows.push_back(make_row(ROW_ITEM, CMD_INSERT, 32'hFFFF_FFFF, 1, 0, STS_OK, 5));
        directed_rows.push_back(make_row(ROW_ITEM, CMD_EXTRACT, 0, 1, 32'h8000_0000, STS_OK, 4));
        directed_rows.push_back(make_row(ROW_ITEM, CMD_EXTRACT, 0, 1, 32'hFFFF_FFFF, STS_OK, 3));
        directed_rows.push_back(make_row(ROW_ITEM, CMD_EXTRACT, 0, 1, 32'hFFFF_FFFF, STS_OK, 2));
        directed_rows.push_back(make_row(ROW_ITEM, CMD_EXTRACT, 0, 1, 32'h0000_0000, STS_OK, 1));
        directed_rows.push_back(make_row(ROW_ITEM, CMD_EXTRACT, 0, 1, 32'h7FFF_FFFF, STS_OK, 0));
        directed_rows.push_back(make_row(ROW_ITEM, CMD_EXTRACT, 32'hFFFF_FFFF, 1, 0, STS_EMPTY, 0));
        // Largest first, with a tie between two fives.
        directed_rows.push_back(make_row(ROW_ORDER, CMD_INSERT, 1, 0, 0, STS_OK, 0));
        directed_rows.push_back(make_row(ROW_ITEM, CMD_INSERT, 5, 1, 0, STS_OK, 1));
        directed_rows.push_back(make_row(ROW_ITEM, CMD_INSERT, 32'h8000_0000, 1, 0, STS_OK, 2));
        directed_rows.push_back(make_row(ROW_ITEM, CMD_INSERT, 32'h7FFF_FFFF, 1, 0, STS_OK, 3));
        directed_rows.push_back(make_row(ROW_ITEM, CMD_INSERT, 5, 1, 0, STS_OK, 4));
        directed_rows.push_back(make_row(ROW_ITEM, CMD_EXTRACT, 0, 1, 32'h7FFF_FFFF, STS_OK, 3));
        directed_rows.push_back(make_row(ROW_ITEM, CMD_EXTRACT, 0, 1, 5, STS_OK, 2));
        directed_rows.push_back(make_row(ROW_ITEM, CMD_EXTRACT, 0, 1, 5, STS_OK, 1));
        directed_rows.push_back(make_row(ROW_ITEM, CMD_EXTRACT, 0, 1, 32'h8000_0000, STS_OK, 0));
        // Fill to capacity, then one insert too many is refused.
        directed_rows.push_back(make_row(ROW_FILL, CMD_INSERT, 0, 0, 0, STS_OK, 0));
        directed_rows.push_back(make_row(ROW_ITEM, CMD_INSERT, 32'h1234_5678, 1, 0, STS_FULL, 64));
        directed_rows.push_back(make_row(ROW_ITEM, CMD_EXTRACT, 0, 0, 0, STS_OK, 0));
        // Switch back with a heap one entry short of full that is ordered the other way round.
        directed_rows.push_back(make_row(ROW_ORDER, CMD_INSERT, 0, 0, 0, STS_OK, 0));

        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (directed_rows[i]) begin
            case (directed_rows[i].kind)
                ROW_ORDER: begin
                    write_order(directed_rows[i].value[0]);
                end
                ROW_FILL: begin
                    while (heap_fill < CAPACITY)
                        send_item(CMD_INSERT, $urandom, 1'b0, no_want);
                end
                default: begin
                    send_item(directed_rows[i].cmd, directed_rows[i].value,
                              directed_rows[i].typed, directed_rows[i].want);
                end
            endcase
        end

        // Random runs, each with its own mix of inserts and extracts, so that
        // the fill level sweeps between empty and full many times. Between runs
        // the order register is rewritten now and then, which also makes the
        // sender wait until every expected result has come back.
        sent = 0;
        while (sent < RANDOM_ITEMS) begin
            run_len = $urandom_range(40, 160);
            case ($urandom_range(4))
                0:       insert_pct = 90;
                1:       insert_pct = 10;
                2:       insert_pct = 50;
                3:       insert_pct = 65;
                default: insert_pct = 35;
            endcase
            if ($urandom_range(1) == 1)
                write_order($urandom_range(1));
            for (int k = 0; k < run_len && sent < RANDOM_ITEMS; k++) begin
                // A long stretch in the middle runs without idle cycles.
                quiet    <= (sent >= 600 && sent < 850);
                cmd_pick = ($urandom_range(99) < insert_pct) ? CMD_INSERT : CMD_EXTRACT;
                send_item(cmd_pick, random_value(), 1'b0, no_want);
                sent++;
            end
        end
        req_if.valid <= 1'b0;
        quiet        <= 1'b0;

        drain = 0;
        while (pending_results.size() != 0 && drain < DRAIN_LIMIT) begin
            @(posedge i_clk);
            drain++;
        end
        repeat (SETTLE_CYCLES) @(posedge i_clk);

        if (mismatch_count == 0 && pending_results.size() == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
